FILE: rtl/wts_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed widths for the weighted transition sampler.
// No dependencies; imported by wts_target and weighted_transition_sampler.
package wts_pkg;

  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int WEIGHT_W   = 32;
  localparam int UNI_W      = 32;
  localparam int TOTAL_BITS = 40;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SMP_ROW,
    ST_SMP_TGT,
    ST_SMP_WALK
  } state_t;

  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } tgt_ctrl_t;

endpackage

FILE: rtl/wts_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/wts_target.sv
`timescale 1ns / 1ps
// Two-stage unit forming the sample target floor(u * total / 2^32) + 1.
// Depends on wts_pkg for widths and the control struct.
module wts_target (
  input  logic                              clk,
  input  wts_pkg::tgt_ctrl_t                ctrl,
  input  logic [wts_pkg::UNI_W-1:0]         uniform,
  input  logic [wts_pkg::TOTAL_BITS-1:0]    total,
  output logic [wts_pkg::TOTAL_BITS:0]      target
);
  import wts_pkg::*;

  localparam int HI_W = TOTAL_BITS - 32;

  logic [UNI_W+32-1:0]   p_lo_r;
  logic [UNI_W+HI_W-1:0] p_hi_r;
  logic [TOTAL_BITS:0]   target_r;

  // stage 1: split the total and form both partial products
  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      p_lo_r <= uniform * total[31:0];
      p_hi_r <= uniform * total[TOTAL_BITS-1:32];
    end
  end

  // stage 2: align and add, then step past the floor
  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      target_r <= (TOTAL_BITS+1)'(p_hi_r) + (TOTAL_BITS+1)'(p_lo_r[UNI_W+32-1:32])
                  + (TOTAL_BITS+1)'(1);
    end
  end

  assign target = target_r;

endmodule

FILE: rtl/weighted_transition_sampler.sv
`timescale 1ns / 1ps
// Weighted transition sampler: saturating count table with per-row column lists.
// An add reads in ST_ADD_RD, writes in ST_ADD_WR, then strobes its result; a sample
// checks the row in ST_SMP_ROW (an empty row strobes there), forms the target in
// ST_SMP_TGT and walks the list in ST_SMP_WALK. Throughput: one item at a time; the
// sample walk reads one list slot per cycle through the order and count memories.
// Reset: after rst_n the count and row memories are swept to zero, busy held high.
// Results are one-cycle strobes; the receiver cannot stall.
module weighted_transition_sampler #(
  parameter int ROWS       = 64,
  parameter int COLS       = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [wts_pkg::ROW_W-1:0]     in_row,
  input  logic [wts_pkg::COL_W-1:0]     in_column,
  input  logic [wts_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic [wts_pkg::UNI_W-1:0]     in_uniform,
  output logic                          out_valid,
  output logic [wts_pkg::COL_W-1:0]     out_picked_column,
  output logic                          out_new_entry,
  output logic                          out_empty_row
);
  import wts_pkg::*;

  localparam int CELLS  = ROWS * COLS;
  localparam int AW     = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam int RW     = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int LEN_W  = $clog2(COLS + 1);
  localparam int DW     = COUNT_BITS > WEIGHT_W ? COUNT_BITS : WEIGHT_W;
  localparam int SW     = DW + 1;
  localparam int TSW    = (DW > TOTAL_BITS ? DW : TOTAL_BITS) + 1;
  localparam int RUN_W  = COUNT_BITS + LEN_W;
  localparam int CMP_W  = RUN_W > TOTAL_BITS + 1 ? RUN_W : TOTAL_BITS + 1;
  localparam int ROWD_W = LEN_W + TOTAL_BITS;

  localparam logic [DW-1:0]         CNT_MAX = DW'({COUNT_BITS{1'b1}});
  localparam logic [TOTAL_BITS-1:0] TOT_MAX = '1;

  // flat address of (row, column) or (row, list slot)
  function automatic logic [AW-1:0] ent_addr(input logic [31:0] r, input logic [31:0] c);
    return AW'(r * 32'(COLS) + c);
  endfunction

  state_t state_r, state_nxt;

  // transfer capture
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [UNI_W-1:0]    uniform_r;

  // working registers
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [COUNT_BITS-1:0] new_cnt_r, new_cnt_nxt;
  logic [DW-1:0]         delta_r, delta_nxt;
  logic                  was_zero_r, was_zero_nxt;
  logic                  do_wr_r, do_wr_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [TOTAL_BITS-1:0] tot_r, tot_nxt;
  logic [LEN_W-1:0]      kidx_r, kidx_nxt;
  logic                  v1_r, v1_nxt, v2_r, v2_nxt;
  logic                  last1_r, last1_nxt, last2_r, last2_nxt;
  logic [COL_W-1:0]      col2_r, col2_nxt;
  logic [RUN_W-1:0]      run_r, run_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [COL_W-1:0] out_pick_r, out_pick_nxt;
  logic             out_new_r, out_new_nxt;
  logic             out_empty_r, out_empty_nxt;

  // memory ports
  logic                  cnt_we, ord_we, row_we;
  logic [AW-1:0]         cnt_waddr, cnt_raddr, ord_waddr, ord_raddr;
  logic [RW-1:0]         row_waddr, row_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [COL_W-1:0]      ord_wdata, ord_rdata;
  logic [ROWD_W-1:0]     row_wdata, row_rdata;

  // datapath terms
  logic                  accept;
  logic                  row_ok, col_ok, add_ok;
  logic [LEN_W-1:0]      len_rd;
  logic [TOTAL_BITS-1:0] tot_rd;
  logic [SW-1:0]         cnt_sum;
  logic                  cnt_sat;
  logic [TSW-1:0]        tot_sum;
  logic [TOTAL_BITS-1:0] tot_new;
  logic                  append;
  logic                  issue;
  logic [RUN_W-1:0]      run_sum;
  logic                  hit;
  logic [TOTAL_BITS:0]   target;
  tgt_ctrl_t             tgt_ctrl;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign row_ok = 32'(row_r) < 32'(ROWS);
  assign col_ok = 32'(col_r) < 32'(COLS);
  assign add_ok = row_ok && col_ok && (weight_r != '0);

  assign len_rd = row_rdata[ROWD_W-1 -: LEN_W];
  assign tot_rd = row_rdata[TOTAL_BITS-1:0];

  assign cnt_sum = SW'(cnt_rdata) + SW'(weight_r);
  assign cnt_sat = cnt_sum > SW'(CNT_MAX);
  assign tot_sum = TSW'(tot_r) + TSW'(delta_r);
  assign tot_new = (tot_sum > TSW'(TOT_MAX)) ? TOT_MAX : tot_sum[TOTAL_BITS-1:0];
  assign append  = was_zero_r && (32'(len_r) < 32'(COLS));

  assign issue   = kidx_r < len_r;
  assign run_sum = run_r + RUN_W'(cnt_rdata);
  assign hit     = CMP_W'(run_sum) >= CMP_W'(target);

  // counts, addressed by (row, column)
  wts_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_cnt_mem (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // column lists in first-insertion order, addressed by (row, slot)
  wts_ram #(.WIDTH(COL_W), .DEPTH(CELLS)) u_ord_mem (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // per-row list length and saturating total
  wts_ram #(.WIDTH(ROWD_W), .DEPTH(ROWS)) u_row_mem (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  assign tgt_ctrl.prod_en = (state_r == ST_SMP_ROW);
  assign tgt_ctrl.sum_en  = (state_r == ST_SMP_TGT);

  wts_target u_target (
    .clk     (clk),
    .ctrl    (tgt_ctrl),
    .uniform (uniform_r),
    .total   (tot_rd),
    .target  (target)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (32'(clr_r) == 32'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = (in_mode == MODE_ADD) ? ST_ADD_RD : ST_SMP_ROW;
      end
      ST_ADD_RD:  state_nxt = ST_ADD_WR;
      ST_ADD_WR:  state_nxt = ST_IDLE;
      ST_SMP_ROW: begin
        state_nxt = (!row_ok || len_rd == '0) ? ST_IDLE : ST_SMP_TGT;
      end
      ST_SMP_TGT: state_nxt = ST_SMP_WALK;
      ST_SMP_WALK: begin
        if (v2_r && (hit || last2_r)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_nxt       = clr_r;
    new_cnt_nxt   = new_cnt_r;
    delta_nxt     = delta_r;
    was_zero_nxt  = was_zero_r;
    do_wr_nxt     = do_wr_r;
    len_nxt       = len_r;
    tot_nxt       = tot_r;
    kidx_nxt      = kidx_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    last1_nxt     = last1_r;
    last2_nxt     = last2_r;
    col2_nxt      = col2_r;
    run_nxt       = run_r;
    out_valid_nxt = 1'b0;
    out_pick_nxt  = out_pick_r;
    out_new_nxt   = out_new_r;
    out_empty_nxt = out_empty_r;

    cnt_we    = 1'b0;
    cnt_waddr = ent_addr(32'(row_r), 32'(col_r));
    cnt_wdata = new_cnt_r;
    ord_we    = 1'b0;
    ord_waddr = ent_addr(32'(row_r), 32'(len_r));
    ord_wdata = col_r;
    row_we    = 1'b0;
    row_waddr = RW'(row_r);
    row_wdata = {len_r, tot_new};

    // count read: fresh transfer in idle, walk address otherwise; row read from in_row
    cnt_raddr = (state_r == ST_IDLE) ? ent_addr(32'(in_row), 32'(in_column))
                                     : ent_addr(32'(row_r), 32'(ord_rdata));
    ord_raddr = ent_addr(32'(row_r), 32'(kidx_r));
    row_raddr = RW'(in_row);

    case (state_r)
      ST_CLEAR: begin
        // sweep counts, and the row memory over its first ROWS addresses
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        if (32'(clr_r) < 32'(ROWS)) begin
          row_we    = 1'b1;
          row_waddr = RW'(clr_r);
          row_wdata = '0;
        end
        clr_nxt = clr_r + AW'(1);
      end
      ST_ADD_RD: begin
        // saturate the count and keep the amount actually added
        new_cnt_nxt  = cnt_sat ? CNT_MAX[COUNT_BITS-1:0] : cnt_sum[COUNT_BITS-1:0];
        delta_nxt    = cnt_sat ? (CNT_MAX - DW'(cnt_rdata)) : DW'(weight_r);
        was_zero_nxt = (cnt_rdata == '0);
        do_wr_nxt    = add_ok;
        len_nxt      = len_rd;
        tot_nxt      = tot_rd;
      end
      ST_ADD_WR: begin
        if (do_wr_r) begin
          cnt_we    = 1'b1;
          row_we    = 1'b1;
          row_wdata = {append ? len_r + LEN_W'(1) : len_r, tot_new};
          ord_we    = append;
        end
        out_valid_nxt = 1'b1;
        out_pick_nxt  = col_r;
        out_new_nxt   = do_wr_r && was_zero_r;
        out_empty_nxt = 1'b0;
      end
      ST_SMP_ROW: begin
        len_nxt   = len_rd;
        kidx_nxt  = '0;
        v1_nxt    = 1'b0;
        v2_nxt    = 1'b0;
        last1_nxt = 1'b0;
        last2_nxt = 1'b0;
        run_nxt   = '0;
        if (!row_ok || len_rd == '0) begin
          out_valid_nxt = 1'b1;
          out_pick_nxt  = '0;
          out_new_nxt   = 1'b0;
          out_empty_nxt = 1'b1;
        end
      end
      ST_SMP_TGT, ST_SMP_WALK: begin
        // slot read, then count read, then accumulate: one slot enters per cycle
        if (issue) kidx_nxt = kidx_r + LEN_W'(1);
        v1_nxt    = issue;
        last1_nxt = issue && (kidx_r == len_r - LEN_W'(1));
        v2_nxt    = v1_r;
        last2_nxt = last1_r;
        col2_nxt  = ord_rdata;
        if (v2_r) begin
          run_nxt = run_sum;
          if (hit) begin
            out_valid_nxt = 1'b1;
            out_pick_nxt  = col2_r;
            out_new_nxt   = 1'b0;
            out_empty_nxt = 1'b0;
          end else if (last2_r) begin
            out_valid_nxt = 1'b1;
            out_pick_nxt  = '0;
            out_new_nxt   = 1'b0;
            out_empty_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
    end
  end

  // payload: hold the transfer, advance the working values
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r     <= in_row;
      col_r     <= in_column;
      weight_r  <= in_weight;
      uniform_r <= in_uniform;
    end
    new_cnt_r  <= new_cnt_nxt;
    delta_r    <= delta_nxt;
    was_zero_r <= was_zero_nxt;
    do_wr_r    <= do_wr_nxt;
    len_r      <= len_nxt;
    tot_r      <= tot_nxt;
    kidx_r     <= kidx_nxt;
    last1_r    <= last1_nxt;
    last2_r    <= last2_nxt;
    col2_r     <= col2_nxt;
    run_r      <= run_nxt;
    out_pick_r  <= out_pick_nxt;
    out_new_r   <= out_new_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_picked_column = out_pick_r;
  assign out_new_entry     = out_new_r;
  assign out_empty_row     = out_empty_r;

endmodule
